### src/nges_pkg.sv
// shared constants and types for the next greater element stack
`timescale 1ns / 1ps
`default_nettype none
package nges_pkg;

    localparam int MAX_LENGTH = 64;
    localparam int VALUE_BITS = 32;
    localparam int DEPTH_BITS = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CNT_BITS   = $clog2(MAX_LENGTH + 1);
    localparam int POS_BITS   = 6;
    localparam int GV_BITS    = 32;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [DEPTH_BITS-1:0]        t_addr;
    typedef logic [CNT_BITS-1:0]          t_cnt;
    typedef logic [POS_BITS-1:0]          t_pos;

    typedef struct packed {
        t_value value;
        t_pos   position;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_entry wdata;
        t_addr  raddr;
    } t_mem_req;

    typedef struct packed {
        t_pos                       position;
        logic signed [GV_BITS-1:0]  greater_value;
        logic                       found;
        logic                       overflow_error;
        logic                       last_result;
    } t_result;

endpackage
`default_nettype wire

### src/nges_mem.sv
// stack storage: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module nges_mem (
    input  wire logic              i_clk,
    input  wire nges_pkg::t_mem_req i_req,
    output nges_pkg::t_entry       o_rd_entry
);

    nges_pkg::t_entry r_mem [nges_pkg::MAX_LENGTH];
    nges_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd <= r_mem[i_req.raddr];
    end

    assign o_rd_entry = r_rd;

endmodule
`default_nettype wire

### src/nges_seq.sv
// sequencer: compare, pop, push and drain against the stack memory
`timescale 1ns / 1ps
`default_nettype none
module nges_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic signed [31:0]   i_sample_value,
    input  wire logic                 i_end_of_sequence,
    input  wire logic                 i_out_free,
    output logic                      o_res_load,
    output nges_pkg::t_result         o_res,
    output nges_pkg::t_mem_req        o_mem_req,
    input  wire nges_pkg::t_entry     i_rd_entry
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CMP   = 5'b00010,
        S_SELF  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_ERR   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    nges_pkg::t_cnt    r_depth, n_depth;
    nges_pkg::t_cnt    r_count, n_count;
    logic              r_hold_valid, n_hold_valid;
    nges_pkg::t_result r_hold, n_hold;
    nges_pkg::t_value  r_val;
    logic              r_last;
    logic              r_ovf;

    logic              in_xfer;
    logic              ovf_now;
    logic              can_emit;
    logic              pop_hit;
    logic              emit;
    logic              flush;
    nges_pkg::t_result new_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign ovf_now    = (r_count >= nges_pkg::t_cnt'(nges_pkg::MAX_LENGTH));
    assign can_emit   = !r_hold_valid || i_out_free;
    assign pop_hit    = (r_depth != '0) && (r_val > i_rd_entry.value);

    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_count      = r_count;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        o_res_load   = 1'b0;
        o_res        = r_hold;
        emit         = 1'b0;
        flush        = 1'b0;
        new_res      = '0;
        o_mem_req.we            = 1'b0;
        o_mem_req.waddr         = r_depth[nges_pkg::DEPTH_BITS-1:0];
        o_mem_req.wdata.value   = r_val;
        o_mem_req.wdata.position = nges_pkg::t_pos'(r_count);

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (!ovf_now) begin
                        n_state = S_CMP;
                    end else if (i_end_of_sequence && (r_depth != '0)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_ERR;
                    end
                end
            end
            S_CMP: begin
                if (can_emit) begin
                    if (pop_hit) begin
                        emit                  = 1'b1;
                        new_res.position      = i_rd_entry.position;
                        new_res.greater_value = nges_pkg::GV_BITS'(r_val);
                        new_res.found         = 1'b1;
                        n_depth               = r_depth - 1'b1;
                    end else if (r_last) begin
                        n_state = S_SELF;
                    end else begin
                        o_mem_req.we = 1'b1;
                        n_depth      = r_depth + 1'b1;
                        n_count      = r_count + 1'b1;
                        flush        = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_SELF: begin
                if (can_emit) begin
                    emit             = 1'b1;
                    new_res.position = nges_pkg::t_pos'(r_count);
                    n_state          = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_depth != '0) begin
                    if (can_emit) begin
                        emit                   = 1'b1;
                        new_res.position       = i_rd_entry.position;
                        new_res.overflow_error = r_ovf;
                        n_depth                = r_depth - 1'b1;
                    end
                end else if (i_out_free) begin
                    flush   = 1'b1;
                    n_depth = '0;
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                if (i_out_free) begin
                    o_res_load           = 1'b1;
                    o_res                = '0;
                    o_res.overflow_error = 1'b1;
                    o_res.last_result    = 1'b1;
                    if (r_last) begin
                        n_depth = '0;
                        n_count = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a result waits in the hold slot until it is known whether it is the last
        if (emit) begin
            n_hold       = new_res;
            n_hold_valid = 1'b1;
            if (r_hold_valid) begin
                o_res_load        = 1'b1;
                o_res             = r_hold;
                o_res.last_result = 1'b0;
            end
        end
        if (flush) begin
            n_hold_valid = 1'b0;
            if (r_hold_valid) begin
                o_res_load        = 1'b1;
                o_res             = r_hold;
                o_res.last_result = 1'b1;
            end
        end

        o_mem_req.raddr = nges_pkg::DEPTH_BITS'(n_depth - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_depth      <= '0;
            r_count      <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_depth      <= n_depth;
            r_count      <= n_count;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (in_xfer) begin
            r_val  <= i_sample_value[nges_pkg::VALUE_BITS-1:0];
            r_last <= i_end_of_sequence;
            r_ovf  <= ovf_now;
        end
    end

endmodule
`default_nettype wire

### src/next_greater_element_stack_top.sv
// top level: next greater element on a monotonic stack with output register
// results: each waits in the sequencer's hold slot until the next result or the end of the item
// is known, then moves to the output register; a lone overflow result is loaded directly
// flow: a new item is accepted only while the sequencer is idle, after the previous item has
// been compared, popped and pushed or drained; a stalled output register holds the flow
// reset: synchronous active low; empties the stack and restarts the sequence count
`timescale 1ns / 1ps
`default_nettype none
module next_greater_element_stack_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [31:0] i_sample_value,
    input  wire logic               i_end_of_sequence,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [5:0]              o_position,
    output logic signed [31:0]      o_greater_value,
    output logic                    o_found,
    output logic                    o_overflow_error,
    output logic                    o_last_result
);

    nges_pkg::t_mem_req mem_req;
    nges_pkg::t_entry   rd_entry;
    nges_pkg::t_result  res;
    logic               res_load;
    logic               out_free;
    logic               r_out_valid;
    nges_pkg::t_result  r_out;

    assign out_free = !r_out_valid || i_out_ready;

    nges_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_sample_value    (i_sample_value),
        .i_end_of_sequence (i_end_of_sequence),
        .i_out_free        (out_free),
        .o_res_load        (res_load),
        .o_res             (res),
        .o_mem_req         (mem_req),
        .i_rd_entry        (rd_entry)
    );

    nges_mem u_mem (
        .i_clk      (i_clk),
        .i_req      (mem_req),
        .o_rd_entry (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_position       = r_out.position;
    assign o_greater_value  = r_out.greater_value;
    assign o_found          = r_out.found;
    assign o_overflow_error = r_out.overflow_error;
    assign o_last_result    = r_out.last_result;

endmodule
`default_nettype wire

### src/nges_checker.sv
// port checker for the next greater element stack, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module nges_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic signed [31:0] i_sample_value,
    input wire logic               i_end_of_sequence,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [5:0]         o_position,
    input wire logic signed [31:0] o_greater_value,
    input wire logic               o_found,
    input wire logic               o_overflow_error,
    input wire logic               o_last_result
);

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready after transfer");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_position)
            && $stable(o_greater_value) && $stable(o_found) && $stable(o_last_result)))
        else $error("result changed under stall");

    // a found result never carries an overflow
    a_found_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_overflow_error))
        else $error("found with overflow");

    // unmatched results carry zero value
    a_zero_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_greater_value == 32'sd0))
        else $error("nonzero value without match");

    // an overflow result at position zero is the bottom entry or a lone error, so it is last
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow_error && (o_position == 6'd0)) |-> o_last_result)
        else $error("overflow result at position zero not last");

endmodule

bind next_greater_element_stack_top nges_checker u_nges_checker (.*);
`default_nettype wire

### bench/tb_top.sv
// self-checking testbench for the next greater element stack
`timescale 1ns / 1ps
module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DIR_ROWS     = 22;

    localparam nges_pkg::t_value  VAL_MIN = 32'sh80000000;
    localparam nges_pkg::t_value  VAL_MAX = 32'sh7fffffff;
    localparam nges_pkg::t_result NO_RES  = '0;

    typedef struct packed {
        nges_pkg::t_value   value;
        logic               eos;
        logic               typed;
        logic [1:0]         n;
        nges_pkg::t_result  r0;
        nges_pkg::t_result  r1;
    } t_dir_row;

    logic          i_clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    nges_pkg::t_value in_sample = '0;
    logic          in_eos = 1'b0;
    int            in_row = -1;
    logic          out_ready = 1'b0;
    logic          o_in_ready;
    logic          o_out_valid;
    logic [5:0]    o_position;
    logic signed [31:0] o_greater_value;
    logic          o_found;
    logic          o_overflow_error;
    logic          o_last_result;

    // stack image and sequence position of the predictor
    nges_pkg::t_value stk_value [nges_pkg::MAX_LENGTH];
    nges_pkg::t_pos   stk_pos [nges_pkg::MAX_LENGTH];
    int            stk_depth = 0;
    int            seq_count = 0;

    nges_pkg::t_result predicted [$];
    nges_pkg::t_result awaited [$];
    int            mismatch_count = 0;
    t_dir_row      dir_rows [DIR_ROWS];

    int            send_left = 0;
    bit            send_quiet = 1'b0;
    int            recv_left = 0;
    bit            recv_quiet = 1'b0;
    int            hold_len = 0;

    next_greater_element_stack_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_sample_value    (in_sample),
        .i_end_of_sequence (in_eos),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_position        (o_position),
        .o_greater_value   (o_greater_value),
        .o_found           (o_found),
        .o_overflow_error  (o_overflow_error),
        .o_last_result     (o_last_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int draw_wait(inout int run_left, inout bit run_quiet);
        if (run_left == 0) begin
            run_left  = $urandom_range(4, 30);
            run_quiet = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return run_quiet ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic nges_pkg::t_value draw_sample();
        case ($urandom_range(0, 3))
            0, 1: return nges_pkg::t_value'(int'($urandom_range(0, 8)) - 4);
            2: return nges_pkg::t_value'($urandom);
            default: begin
                case ($urandom_range(0, 5))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    3: return -1;
                    4: return VAL_MIN + 1;
                    default: return VAL_MAX - 1;
                endcase
            end
        endcase
    endfunction

    function automatic void add_result(nges_pkg::t_pos pos, nges_pkg::t_value gv, logic fnd,
                                       logic ovf);
        predicted.push_back('{position: pos, greater_value: gv, found: fnd,
                              overflow_error: ovf, last_result: 1'b0});
    endfunction

    // pops smaller entries, pushes the new one, drains at end of sequence; flags overflow if full
    function automatic void compute_greater_results(nges_pkg::t_value v, logic eos);
        predicted.delete();
        if (seq_count >= nges_pkg::MAX_LENGTH) begin
            if (eos) begin
                while (stk_depth > 0) begin
                    stk_depth--;
                    add_result(stk_pos[stk_depth], '0, 1'b0, 1'b1);
                end
            end
            if (predicted.size() == 0)
                add_result('0, '0, 1'b0, 1'b1);
            if (eos) begin
                stk_depth = 0;
                seq_count = 0;
            end
        end else begin
            while (stk_depth > 0 && v > stk_value[stk_depth-1]) begin
                stk_depth--;
                add_result(stk_pos[stk_depth], v, 1'b1, 1'b0);
            end
            stk_value[stk_depth] = v;
            stk_pos[stk_depth]   = nges_pkg::t_pos'(seq_count);
            stk_depth++;
            seq_count++;
            if (eos) begin
                while (stk_depth > 0) begin
                    stk_depth--;
                    add_result(stk_pos[stk_depth], '0, 1'b0, 1'b0);
                end
                seq_count = 0;
            end
        end
        if (predicted.size() > 0)
            predicted[predicted.size()-1].last_result = 1'b1;
    endfunction

    // transfer monitor: predicts on input transfers, checks on output transfers
    always @(posedge i_clk) begin
        nges_pkg::t_result got;
        nges_pkg::t_result exp_res;
        if (rst_n) begin
            if (o_out_valid && out_ready) begin
                got = '{o_position, o_greater_value, o_found, o_overflow_error,
                        o_last_result};
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result pos=%0d gv=%0d found=%b ovf=%b last=%b",
                             $time, got.position, got.greater_value, got.found,
                             got.overflow_error, got.last_result);
                    mismatch_count++;
                end else begin
                    exp_res = awaited.pop_front();
                    if (got !== exp_res) begin
                        $display("%0t: mismatch expected pos=%0d gv=%0d found=%b ovf=%b last=%b",
                                 $time, exp_res.position, exp_res.greater_value,
                                 exp_res.found, exp_res.overflow_error,
                                 exp_res.last_result);
                        $display("%0t:          actual   pos=%0d gv=%0d found=%b ovf=%b last=%b",
                                 $time, got.position, got.greater_value, got.found,
                                 got.overflow_error, got.last_result);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && o_in_ready) begin
                compute_greater_results(in_sample, in_eos);
                if (in_row >= 0 && dir_rows[in_row].typed) begin
                    if (dir_rows[in_row].n > 0)
                        awaited.push_back(dir_rows[in_row].r0);
                    if (dir_rows[in_row].n > 1)
                        awaited.push_back(dir_rows[in_row].r1);
                end else begin
                    foreach (predicted[k])
                        awaited.push_back(predicted[k]);
                end
            end
        end
    end

    // returns at the edge where the sample was transferred
    task automatic send_sample(nges_pkg::t_value v, logic eos, int row);
        int gap;
        gap = draw_wait(send_left, send_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_sample <= v;
        in_eos    <= eos;
        in_row    <= row;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // result side: random stalls plus one long hold on request
    initial begin
        int stall;
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end
            stall = draw_wait(recv_left, recv_quiet);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int     seq_num;
        int     sent;
        int     len;
        nges_pkg::t_value v;

        dir_rows = '{
            '{32'sd5, 1'b1, 1'b1, 2'd1, '{6'd0, 32'sd0, 1'b0, 1'b0, 1'b1}, NO_RES},
            '{VAL_MIN, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
            '{VAL_MAX, 1'b0, 1'b1, 2'd1, '{6'd0, VAL_MAX, 1'b1, 1'b0, 1'b1}, NO_RES},
            '{VAL_MAX, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
            '{VAL_MIN, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
            '{-32'sd1, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
            '{32'sd0, 1'b0, 1'b1, 2'd1, '{6'd0, 32'sd0, 1'b1, 1'b0, 1'b1}, NO_RES},
            '{32'sd3, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sd3, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sd2, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sd7, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sd1, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sd9, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sd8, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sd7, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sd6, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sd10, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{-32'sd5, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sh55555555, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'shaaaaaaaa, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sh55555555, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{32'sh7ffffffe, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES}
        };

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_sample(dir_rows[r].value, dir_rows[r].eos, r);

        seq_num = 0;
        sent    = 0;
        while (sent < RANDOM_ITEMS) begin
            if (seq_num == 1) begin
                // rising run while the result side is held off: every transfer after the first pops
                hold_len = HOLD_CYCLES;
                v = VAL_MIN + nges_pkg::t_value'($urandom_range(0, 1000));
                for (int k = 0; k < 20; k++) begin
                    v = v + nges_pkg::t_value'($urandom_range(1, 100000));
                    send_sample(v, k == 19, -1);
                end
                sent += 20;
            end else if (seq_num == 3) begin
                // quiet the block, then fill the stack and run past the length limit
                in_valid <= 1'b0;
                @(posedge i_clk);
                while (awaited.size() != 0) @(posedge i_clk);
                v = nges_pkg::t_value'($urandom_range(0, 1000000));
                for (int k = 0; k < nges_pkg::MAX_LENGTH; k++) begin
                    send_sample(v, 1'b0, -1);
                    v = v - nges_pkg::t_value'($urandom_range(0, 2));
                end
                send_sample(draw_sample(), 1'b0, -1);
                send_sample(draw_sample(), 1'b1, -1);
                sent += nges_pkg::MAX_LENGTH + 2;
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30)
                                                  : $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                    send_sample(draw_sample(), k == len - 1, -1);
                sent += len;
            end
            seq_num++;
        end

        in_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && awaited.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
src/nges_pkg.sv
src/nges_mem.sv
src/nges_seq.sv
src/next_greater_element_stack_top.sv
src/nges_checker.sv
bench/tb_top.sv
